### design/serial_frame_deframer_top_defines.svh
// ---------------------------------------------------------------------------
// serial_frame_deframer_top_defines
// Assertion macros shared by the deframer RTL.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// Types and constants of the serial frame deframer.
// ---------------------------------------------------------------------------
package sfd_pkg;

	localparam int BYTE_W      = 8;
	localparam int SPEED_W     = 16;
	localparam int SPEED_BYTES = 16;
	localparam int SPEED_CNT   = 8;
	localparam int SPEED_IDX_W = 4;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 3;

	// result payload layout, lowest bit first
	localparam int TEXT_LSB   = 0;
	localparam int STATUS_LSB = TEXT_LSB + BYTE_W;
	localparam int CMD_LSB    = STATUS_LSB + STATUS_W;
	localparam int SPEED_LSB  = CMD_LSB + BYTE_W;
	localparam int PAYLOAD_W  = SPEED_LSB + SPEED_CNT * SPEED_W;
	localparam int TDATA_W    = ((PAYLOAD_W + 7) / 8) * 8;

	typedef enum logic [5:0] {
		PH_SYNC1 = 6'b000001,
		PH_SYNC2 = 6'b000010,
		PH_LEN   = 6'b000100,
		PH_CMD   = 6'b001000,
		PH_PAY   = 6'b010000,
		PH_SUM   = 6'b100000
	} phase_t;

	localparam logic [STATUS_W-1:0] ST_GOOD      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CHECKSUM  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd3;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRING_CMD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_CMD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN   = 3'd4;

	localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'h55;
	localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'haa;
	localparam logic [BYTE_W-1:0] RST_STRING_CMD  = 8'h01;
	localparam logic [BYTE_W-1:0] RST_SPEED_CMD   = 8'h20;
	localparam logic              RST_BIG_ENDIAN  = 1'b1;

endpackage

### design/serial_frame_deframer_top.sv
// ---------------------------------------------------------------------------
// serial_frame_deframer_top
// Parses sync / length / command / payload / checksum frames from a serial
// byte stream; emits text bytes and frame-end records with speeds.
// ---------------------------------------------------------------------------
// channel   dir  handshake          contents
// s_*       in   tvalid/tready      tdata[7:0] rx_byte
// m_*       out  tvalid/tready      tuser result_kind, tdata text/status/cmd/speeds
// cfg_*     in   cfg_wen            cfg_index, cfg_data (no read-back)
//
// One byte per cycle while s_tready is high; each byte is parsed in the cycle
// it is accepted and its result lands in the output register on the next edge.
// s_tready drops only while a result sits unaccepted and m_tready is low.
// Reset returns to the first-sync search; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "serial_frame_deframer_top_defines.svh"

module serial_frame_deframer_top
	import sfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,   // text_byte, frame_status, frame_command,
	                                        // speed_a .. speed_h, zero pad
	output logic                 m_tuser,   // result_kind
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	logic [BYTE_W-1:0] sync_first_q, sync_second_q, string_cmd_q, speed_cmd_q;
	logic              big_endian_q;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] seen_q, seen_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] speed_q [SPEED_BYTES];

	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [PAYLOAD_W-1:0] out_data_q;

	logic                 accept;
	logic [BYTE_W-1:0]    rx;
	logic [BYTE_W-1:0]    seen_inc;
	logic                 is_text, is_speed;
	logic                 speed_wr;
	logic                 res_valid, res_kind;
	logic [STATUS_W-1:0]  status;
	logic [PAYLOAD_W-1:0] res_data;
	logic [SPEED_W-1:0]   speeds [SPEED_CNT];

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;
	assign rx       = s_tdata;
	assign seen_inc = seen_q + 8'd1;
	assign is_text  = (cmd_q == string_cmd_q);
	assign is_speed = !is_text && (cmd_q == speed_cmd_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= RST_SYNC_FIRST;
			sync_second_q <= RST_SYNC_SECOND;
			string_cmd_q  <= RST_STRING_CMD;
			speed_cmd_q   <= RST_SPEED_CMD;
			big_endian_q  <= RST_BIG_ENDIAN;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				REG_STRING_CMD:  string_cmd_q  <= cfg_data;
				REG_SPEED_CMD:   speed_cmd_q   <= cfg_data;
				REG_BIG_ENDIAN:  big_endian_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < SPEED_CNT; i++) begin
			speeds[i] = big_endian_q ? {speed_q[2*i], speed_q[2*i+1]}
			                         : {speed_q[2*i+1], speed_q[2*i]};
		end
	end

	always_comb begin
		if (rx != sum_q) begin
			status = ST_CHECKSUM;
		end else if (!is_text && !is_speed) begin
			status = ST_UNKNOWN;
		end else if (is_speed && (seen_q < BYTE_W'(SPEED_BYTES))) begin
			status = ST_SHORT;
		end else begin
			status = ST_GOOD;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		seen_d    = seen_q;
		len_d     = len_q;
		cmd_d     = cmd_q;
		sum_d     = sum_q;
		speed_wr  = 1'b0;
		res_valid = 1'b0;
		res_kind  = KIND_TEXT;
		res_data  = '0;
		unique case (phase_q)
			PH_SYNC2: begin
				phase_d = (rx == sync_second_q) ? PH_LEN : PH_SYNC1;
			end
			PH_LEN: begin
				if (rx == '0) begin
					phase_d = PH_SYNC1;   // zero length: resync
				end else begin
					len_d   = rx;
					sum_d   = rx;
					seen_d  = '0;
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				cmd_d   = rx;
				sum_d   = sum_q + rx;
				phase_d = (len_q == 8'd1) ? PH_SUM : PH_PAY;
			end
			PH_PAY: begin
				sum_d  = sum_q + rx;
				seen_d = seen_inc;
				if (is_text) begin
					res_valid = 1'b1;
					res_kind  = KIND_TEXT;
					res_data[TEXT_LSB +: BYTE_W] = rx;
					res_data[CMD_LSB +: BYTE_W]  = cmd_q;
				end else if (is_speed && (seen_q < BYTE_W'(SPEED_BYTES))) begin
					speed_wr = 1'b1;
				end
				if (seen_inc >= len_q - 8'd1) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: begin
				res_valid = 1'b1;
				res_kind  = KIND_END;
				res_data[STATUS_LSB +: STATUS_W] = status;
				res_data[CMD_LSB +: BYTE_W]      = cmd_q;
				if (status == ST_GOOD && is_speed) begin
					for (int i = 0; i < SPEED_CNT; i++) begin
						res_data[SPEED_LSB + i*SPEED_W +: SPEED_W] = speeds[i];
					end
				end
				phase_d = PH_SYNC1;
			end
			default: begin
				phase_d = (rx == sync_first_q) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			seen_q  <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			seen_q  <= seen_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
			sum_q   <= sum_d;
		end
	end

	// speed byte store, contents undefined until written
	always_ff @(posedge clk) begin
		if (accept && speed_wr) begin
			speed_q[seen_q[SPEED_IDX_W-1:0]] <= rx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_kind_q <= res_kind;
			out_data_q <= res_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {{(TDATA_W-PAYLOAD_W){1'b0}}, out_data_q};

	`SFD_ASSERT_NEXT(a_sum_gives_end, accept && phase_q == PH_SUM,
		m_tvalid && m_tuser == KIND_END, "checksum byte did not produce a frame end")
	`SFD_ASSERT_NEXT(a_header_silent,
		accept && (phase_q == PH_SYNC1 || phase_q == PH_SYNC2 ||
		phase_q == PH_LEN || phase_q == PH_CMD),
		!m_tvalid, "header byte produced a request")
	`SFD_ASSERT_NOW(a_text_status, m_tvalid && m_tuser == KIND_TEXT,
		m_tdata[STATUS_LSB +: STATUS_W] == ST_GOOD, "text request carries a status")
	`SFD_ASSERT_NOW(a_pay_bound, phase_q == PH_PAY,
		seen_q < len_q - 8'd1, "payload count ran past frame length")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Serial frame deframer check. Bytes go in on the s_* stream with random gaps;
// a byte-level parser model in this file predicts text bytes and frame-end
// records, and every result accepted on the m_* stream is compared field by
// field. Covers sync errors, zero and one lengths, every frame status, equal
// command codes, both speed byte orders, register extremes and backpressure.
// ---------------------------------------------------------------------------
module testbench
	import sfd_pkg::*;
();

	localparam int IDLE_LIMIT = 2000;
	localparam int PRINT_CAP  = 50;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct packed {
		logic                                 kind;
		logic [SPEED_CNT-1:0][SPEED_W-1:0]    speeds;
		logic [BYTE_W-1:0]                    cmd;
		logic [STATUS_W-1:0]                  status;
		logic [BYTE_W-1:0]                    text;
	} frame_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tuser;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	// register copies
	logic [BYTE_W-1:0] cfg_sync_first  = RST_SYNC_FIRST;
	logic [BYTE_W-1:0] cfg_sync_second = RST_SYNC_SECOND;
	logic [BYTE_W-1:0] cfg_string_cmd  = RST_STRING_CMD;
	logic [BYTE_W-1:0] cfg_speed_cmd   = RST_SPEED_CMD;
	logic              cfg_big_endian  = RST_BIG_ENDIAN;

	// parser state
	phase_t            rx_phase     = PH_SYNC1;
	logic [8:0]        payload_seen = '0;
	logic [BYTE_W-1:0] frame_len    = '0;
	logic [BYTE_W-1:0] frame_cmd    = '0;
	logic [BYTE_W-1:0] running_sum  = '0;
	logic [BYTE_W-1:0] speed_store [SPEED_BYTES];

	frame_result_t pending_results[$];

	int  mismatches = 0;
	int  bytes_sent = 0;
	int  stalled_cycles = 0;
	int  rx_stall = 0;
	int  rx_hold_request = 0;
	bit  tx_gaps_on = 1'b1;
	bit  rx_gaps_on = 1'b1;

	serial_frame_deframer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return $urandom_range(10, 40);
		else if (r < 6)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		if (mismatches < PRINT_CAP)
			$display("tb: %s mismatch at %0t ns: got 0x%0h, expected 0x%0h",
				field, $time, got, want);
		mismatches++;
	endtask

	// advance the parser by one accepted byte and queue whatever it emits
	task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
		frame_result_t r;
		logic is_text;
		logic is_speed;
		r = '0;
		case (rx_phase)
			PH_SYNC2: begin
				rx_phase = (b == cfg_sync_second) ? PH_LEN : PH_SYNC1;
			end
			PH_LEN: begin
				if (b == 8'd0) begin
					rx_phase = PH_SYNC1;
				end else begin
					frame_len    = b;
					running_sum  = b;
					payload_seen = '0;
					rx_phase     = PH_CMD;
				end
			end
			PH_CMD: begin
				frame_cmd   = b;
				running_sum = running_sum + b;
				rx_phase    = (frame_len == 8'd1) ? PH_SUM : PH_PAY;
			end
			PH_PAY: begin
				running_sum = running_sum + b;
				if (frame_cmd == cfg_string_cmd) begin
					r.kind = KIND_TEXT;
					r.text = b;
					r.cmd  = frame_cmd;
					pending_results.push_back(r);
				end else if (frame_cmd == cfg_speed_cmd && payload_seen < SPEED_BYTES) begin
					speed_store[payload_seen[SPEED_IDX_W-1:0]] = b;
				end
				payload_seen = payload_seen + 9'd1;
				if (payload_seen >= {1'b0, frame_len} - 9'd1)
					rx_phase = PH_SUM;
			end
			PH_SUM: begin
				// equal codes resolve to text
				is_text  = (frame_cmd == cfg_string_cmd);
				is_speed = !is_text && (frame_cmd == cfg_speed_cmd);
				r.kind   = KIND_END;
				r.cmd    = frame_cmd;
				if (b != running_sum)
					r.status = ST_CHECKSUM;
				else if (!is_text && !is_speed)
					r.status = ST_UNKNOWN;
				else if (is_speed && payload_seen < SPEED_BYTES)
					r.status = ST_SHORT;
				else
					r.status = ST_GOOD;
				if (r.status == ST_GOOD && is_speed) begin
					for (int i = 0; i < SPEED_CNT; i++)
						r.speeds[i] = cfg_big_endian ?
							{speed_store[2*i], speed_store[2*i+1]} :
							{speed_store[2*i+1], speed_store[2*i]};
				end
				pending_results.push_back(r);
				rx_phase = PH_SYNC1;
			end
			default: begin
				rx_phase = (b == cfg_sync_first) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	endtask

	// valid stays up across back-to-back bytes; it only drops for a gap
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		parse_rx_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] cmd,
			input fill_t fill, input bit bad_sum);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		send_byte(cfg_sync_first);
		send_byte(cfg_sync_second);
		send_byte(len);
		if (len == 8'd0)
			return;
		send_byte(cmd);
		sum = len + cmd;
		for (int k = 1; k < len; k++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hff;
				default:   b = 8'($urandom);
			endcase
			send_byte(b);
			sum = sum + b;
		end
		send_byte(bad_sum ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// bytes with no result may still be in flight
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		case (idx)
			REG_SYNC_FIRST:  cfg_sync_first  = d;
			REG_SYNC_SECOND: cfg_sync_second = d;
			REG_STRING_CMD:  cfg_string_cmd  = d;
			REG_SPEED_CMD:   cfg_speed_cmd   = d;
			REG_BIG_ENDIAN:  cfg_big_endian  = d[0];
			default: ;
		endcase
	endtask

	// call only when idle
	task automatic apply_config(input logic [BYTE_W-1:0] sf, input logic [BYTE_W-1:0] ss,
			input logic [BYTE_W-1:0] sc, input logic [BYTE_W-1:0] spc, input logic be);
		write_cfg(REG_SYNC_FIRST, sf);
		write_cfg(REG_SYNC_SECOND, ss);
		write_cfg(REG_STRING_CMD, sc);
		write_cfg(REG_SPEED_CMD, spc);
		write_cfg(REG_BIG_ENDIAN, {7'd0, be});
		cfg_wen <= 1'b0;
	endtask

	task automatic test_default_frames();
		send_frame(8'd3, cfg_string_cmd, FILL_ONES, 1'b0);
		send_frame(8'd2, cfg_string_cmd, FILL_ZERO, 1'b0);
		send_frame(8'd17, cfg_speed_cmd, FILL_RANDOM, 1'b0);
	endtask

	task automatic test_sync_recovery();
		send_byte(~cfg_sync_first);
		// wrong second sync that equals the first drops back to the first-sync search and is not taken as a new first sync
		send_byte(cfg_sync_first);
		send_byte(cfg_sync_first);
		send_byte(cfg_sync_second);
		send_frame(8'd0, 8'd0, FILL_RANDOM, 1'b0);
		send_frame(8'd1, cfg_string_cmd, FILL_RANDOM, 1'b0);
	endtask

	task automatic test_frame_status();
		send_frame(8'd2, cfg_string_cmd, FILL_RANDOM, 1'b1);
		send_frame(8'd1, 8'h77, FILL_RANDOM, 1'b0);
		send_frame(8'd2, 8'h77, FILL_RANDOM, 1'b1);
		send_frame(8'd1, cfg_speed_cmd, FILL_RANDOM, 1'b0);
		send_frame(8'd5, cfg_speed_cmd, FILL_RANDOM, 1'b0);
		send_frame(8'd3, cfg_speed_cmd, FILL_RANDOM, 1'b1);
	endtask

	task automatic test_equal_codes();
		wait_drain();
		apply_config(RST_SYNC_FIRST, RST_SYNC_SECOND, 8'h7e, 8'h7e, 1'b0);
		send_frame(8'd3, 8'h7e, FILL_RANDOM, 1'b0);
	endtask

	// receiver stalls long while a long text frame streams in
	task automatic test_backpressure();
		wait_drain();
		apply_config(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_STRING_CMD, RST_SPEED_CMD,
			RST_BIG_ENDIAN);
		tx_gaps_on = 1'b0;
		rx_hold_request = 300;
		send_frame(8'd40, cfg_string_cmd, FILL_RANDOM, 1'b0);
		tx_gaps_on = 1'b1;
		wait_drain();
	endtask

	task automatic random_traffic(input int n_bytes);
		int target;
		int pick;
		int n;
		logic [BYTE_W-1:0] len;
		logic [BYTE_W-1:0] cmd;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				n = $urandom_range(0, 9);
				if (n < 4) begin
					cmd = cfg_string_cmd;
					len = ($urandom_range(0, 59) == 0) ? 8'd255 : 8'($urandom_range(1, 12));
				end else if (n < 8) begin
					cmd = cfg_speed_cmd;
					len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 16)) :
						8'($urandom_range(17, 22));
				end else begin
					cmd = 8'($urandom);
					while (cmd == cfg_string_cmd || cmd == cfg_speed_cmd)
						cmd = cmd + 8'd1;
					len = (n == 9) ? 8'd0 : 8'($urandom_range(1, 8));
				end
				send_frame(len, cmd, FILL_RANDOM, $urandom_range(0, 9) == 0);
			end else if (pick < 90) begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(8'($urandom));
			end else if (pick < 95) begin
				send_byte(cfg_sync_first);
				send_byte(cfg_sync_second ^ (8'h01 << $urandom_range(0, 7)));
			end else begin
				send_byte(cfg_sync_first);
				send_byte(cfg_sync_first);
				send_byte(cfg_sync_second);
			end
		end
	endtask

	task automatic test_config_sweep();
		logic [BYTE_W-1:0] cmd;
		random_traffic(160);
		wait_drain();
		apply_config(8'h00, 8'hff, 8'hff, 8'h00, 1'b0);
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		random_traffic(160);
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		wait_drain();
		cmd = 8'($urandom);
		apply_config(8'hff, 8'h00, cmd, cmd, 1'b1);
		random_traffic(160);
		wait_drain();
		apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom));
		random_traffic(160);
	endtask

	always @(posedge clk) begin
		if (rx_hold_request > 0) begin
			rx_stall = rx_hold_request;
			rx_hold_request = 0;
		end
		if (rx_stall > 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (rx_gaps_on)
				rx_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, kind", m_tuser, 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("result_kind", m_tuser, want.kind);
				if (m_tdata[TEXT_LSB +: BYTE_W] !== want.text)
					report_mismatch("text_byte", m_tdata[TEXT_LSB +: BYTE_W], want.text);
				if (m_tdata[STATUS_LSB +: STATUS_W] !== want.status)
					report_mismatch("frame_status", m_tdata[STATUS_LSB +: STATUS_W],
						want.status);
				if (m_tdata[CMD_LSB +: BYTE_W] !== want.cmd)
					report_mismatch("frame_command", m_tdata[CMD_LSB +: BYTE_W], want.cmd);
				for (int i = 0; i < SPEED_CNT; i++)
					if (m_tdata[SPEED_LSB + i*SPEED_W +: SPEED_W] !== want.speeds[i])
						report_mismatch($sformatf("speed %0d", i),
							m_tdata[SPEED_LSB + i*SPEED_W +: SPEED_W], want.speeds[i]);
			end
		end
	end

	// no request moving for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stalled_cycles = 0;
		end else begin
			stalled_cycles++;
			if (stalled_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_frames();
		test_sync_recovery();
		test_frame_status();
		test_equal_codes();
		test_backpressure();
		test_config_sweep();
		wait_drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### files.f
+incdir+design
design/sfd_pkg.sv
design/serial_frame_deframer_top.sv
dv/testbench.sv
